// File: hw/rtl/first_fit_heap_allocator_assert.svh
// Assertion macros for the heap allocator checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HFA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("heap allocator check failed");

// Next-cycle implication, disabled while reset is low.
`define HFA_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("heap allocator check failed");

`endif

// File: hw/rtl/hfa_pkg.sv
package hfa_pkg;

  localparam int HEAP_GRANULES_DEF = 4096;
  localparam int GRANULE_SHIFT     = 3;
  localparam int CFG_W             = 13;
  localparam int ACTION_W          = 2;
  localparam int REQ_W             = 16;
  localparam int OFFSET_W          = 15;
  localparam int TASK_W            = 8;
  localparam int COUNT_W           = 13;

  typedef logic [ACTION_W-1:0] action_t;

  localparam action_t ACT_ALLOC = 2'd0;
  localparam action_t ACT_FREE  = 2'd1;
  localparam action_t ACT_COUNT = 2'd2;
  localparam action_t ACT_INIT  = 2'd3;

endpackage

// File: hw/rtl/hfa_in_if.sv
interface hfa_in_if;
  import hfa_pkg::*;

  logic                valid;
  logic                ready;
  action_t             action;
  logic [REQ_W-1:0]    request_bytes;
  logic [OFFSET_W-1:0] block_offset;
  logic [TASK_W-1:0]   task_id;

  modport source (output valid, action, request_bytes, block_offset, task_id, input ready);
  modport sink   (input valid, action, request_bytes, block_offset, task_id, output ready);
endinterface

// File: hw/rtl/hfa_out_if.sv
interface hfa_out_if;
  import hfa_pkg::*;

  logic                valid;
  logic                ready;
  logic                status;
  logic [OFFSET_W-1:0] payload_offset;
  logic [COUNT_W-1:0]  small_block_count;

  modport source (output valid, status, payload_offset, small_block_count, input ready);
  modport sink   (input valid, status, payload_offset, small_block_count, output ready);
endinterface

// File: hw/rtl/hfa_mem.sv
module hfa_mem #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 23
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

// File: hw/rtl/first_fit_heap_allocator.sv
// First-fit heap allocator over a heap of 8-byte granules.
// Channels: in_ch (sink) carries action, request_bytes, block_offset and
// task_id; out_ch (source) returns status, payload_offset and
// small_block_count, exactly one result per transfer on in_ch. cfg_we with
// cfg_wdata sets the heap size in granules, picked up by the next
// initialise action.
// All block headers live in one synchronous single-port-read memory of
// HEAP_GRANULES entries. Allocate, count and the merge step of free walk the
// header chain, issuing the address of each block visited and then evaluating
// its read data. A block is at least two granules.
// Initialise clears the whole header memory, one entry a cycle, and then
// writes the single free block.
// After reset the same clearing pass runs, with in_ch.ready low; the heap
// then reports failure until initialised.
// One item is worked on at a time. A finished result sits in the output
// register; if the receiver stalls, the next item is still taken, and its
// result waits until the previous one has been transferred.
module first_fit_heap_allocator #(
  parameter int HEAP_GRANULES = hfa_pkg::HEAP_GRANULES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  hfa_in_if.sink                   in_ch,
  hfa_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [hfa_pkg::CFG_W-1:0] cfg_wdata
);
  import hfa_pkg::*;

  localparam int GW = (HEAP_GRANULES > 1) ? $clog2(HEAP_GRANULES) : 1;
  localparam int SW = $clog2(HEAP_GRANULES + 1);
  localparam int CW = ((SW > 14) ? SW : 14) + 2;
  localparam int EW = SW + 10;

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_BASE  = 4'd1;
  localparam logic [3:0] ST_IDLE  = 4'd2;
  localparam logic [3:0] ST_AISS  = 4'd3;
  localparam logic [3:0] ST_AEV   = 4'd4;
  localparam logic [3:0] ST_ASPL  = 4'd5;
  localparam logic [3:0] ST_FGISS = 4'd6;
  localparam logic [3:0] ST_FGEV  = 4'd7;
  localparam logic [3:0] ST_FNISS = 4'd8;
  localparam logic [3:0] ST_FNEV  = 4'd9;
  localparam logic [3:0] ST_FWG   = 4'd10;
  localparam logic [3:0] ST_PISS  = 4'd11;
  localparam logic [3:0] ST_PEV   = 4'd12;
  localparam logic [3:0] ST_PDROP = 4'd13;
  localparam logic [3:0] ST_CWALK = 4'd14;
  localparam logic [3:0] ST_DONE  = 4'd15;

  // Count walk shares the issue/evaluate split: CWALK issues, AEV-like eval
  // is folded in by the cnt_eval_r flag.
  logic [3:0]          state_r, state_nxt;
  logic                cnt_eval_r, cnt_eval_nxt;
  logic                init_r, init_nxt;
  logic [GW-1:0]       clr_r, clr_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       need_r, need_nxt;
  logic [CW-1:0]       fsz_r, fsz_nxt;
  logic [CW-1:0]       g_r, g_nxt;
  logic [SW-1:0]       len_r, len_nxt;
  logic [SW-1:0]       used_r, used_nxt;
  logic                rdy_r, rdy_nxt;
  logic [REQ_W-1:0]    thr_r, thr_nxt;
  logic [TASK_W-1:0]   task_r, task_nxt;
  logic [CFG_W-1:0]    cfg_r, cfg_nxt;
  logic                st_r, st_nxt;
  logic [OFFSET_W-1:0] pay_r, pay_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic                ov_r, ov_nxt;
  logic                ost_r, ost_nxt;
  logic [OFFSET_W-1:0] opay_r, opay_nxt;
  logic [COUNT_W-1:0]  ocnt_r, ocnt_nxt;

  logic          wr_en, rd_en;
  logic [GW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, rd_data;

  logic          e_start, e_alloc;
  logic [CW-1:0] e_size;
  logic [TASK_W-1:0] e_owner;
  logic [CW-1:0] in_need, in_g, sum_used;
  logic [31:0]   sat_n, pay_w;
  logic [CW+2:0] sz_bytes;

  hfa_mem #(.DEPTH(2 ** GW), .DATA_W(EW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Header entry: start mark, allocated mark, size in granules, owner.
  assign e_start = rd_data[EW-1];
  assign e_alloc = rd_data[EW-2];
  assign e_size  = CW'(rd_data[SW+7:8]);
  assign e_owner = rd_data[7:0];

  // Round up one bit wider than the request so the largest requests carry.
  assign in_need  = CW'(({1'b0, in_ch.request_bytes} + (REQ_W+1)'(7)) >> GRANULE_SHIFT) + CW'(1);
  assign in_g     = CW'(in_ch.block_offset >> GRANULE_SHIFT) - CW'(1);
  assign sum_used = CW'(used_r) + in_need;
  assign sz_bytes = (CW+3)'(e_size) << GRANULE_SHIFT;
  assign pay_w    = (32'(pos_r) + 32'd1) << GRANULE_SHIFT;

  always_comb begin
    sat_n = 32'(cfg_r);
    if (sat_n < 32'd4) begin
      sat_n = 32'd4;
    end
    if (sat_n > 32'(HEAP_GRANULES)) begin
      sat_n = 32'(HEAP_GRANULES);
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cnt_eval_nxt = cnt_eval_r;
    init_nxt     = init_r;
    clr_nxt      = clr_r;
    pos_nxt      = pos_r;
    need_nxt     = need_r;
    fsz_nxt      = fsz_r;
    g_nxt        = g_r;
    len_nxt      = len_r;
    used_nxt     = used_r;
    rdy_nxt      = rdy_r;
    thr_nxt      = thr_r;
    task_nxt     = task_r;
    cfg_nxt      = cfg_we ? cfg_wdata : cfg_r;
    st_nxt       = st_r;
    pay_nxt      = pay_r;
    cnt_nxt      = cnt_r;
    ov_nxt       = ov_r && !out_ch.ready;
    ost_nxt      = ost_r;
    opay_nxt     = opay_r;
    ocnt_nxt     = ocnt_r;
    wr_en        = 1'b0;
    wr_addr      = g_r[GW-1:0];
    wr_data      = '0;
    rd_en        = 1'b0;
    rd_addr      = pos_r[GW-1:0];

    case (state_r)
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + GW'(1);
        if (clr_r == GW'(HEAP_GRANULES - 1)) begin
          state_nxt = init_r ? ST_BASE : ST_IDLE;
        end
      end
      ST_BASE: begin
        // Single free block spanning the whole heap.
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = {1'b1, 1'b0, len_r, 8'd0};
        used_nxt  = '0;
        rdy_nxt   = 1'b1;
        st_nxt    = 1'b0;
        state_nxt = ST_DONE;
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          st_nxt   = 1'b1;
          pay_nxt  = '0;
          cnt_nxt  = '0;
          pos_nxt  = '0;
          task_nxt = in_ch.task_id;
          thr_nxt  = in_ch.request_bytes;
          need_nxt = in_need;
          g_nxt    = in_g;
          state_nxt = ST_DONE;
          case (in_ch.action)
            ACT_ALLOC: begin
              if (rdy_r && (in_ch.request_bytes != '0) && (sum_used <= CW'(len_r))) begin
                state_nxt = ST_AISS;
              end
            end
            ACT_FREE: begin
              if (rdy_r && (in_ch.block_offset >= OFFSET_W'(8)) &&
                  (in_ch.block_offset[GRANULE_SHIFT-1:0] == '0) &&
                  (in_g < CW'(len_r))) begin
                state_nxt = ST_FGISS;
              end
            end
            ACT_COUNT: begin
              if (rdy_r) begin
                st_nxt       = 1'b0;
                cnt_eval_nxt = 1'b0;
                state_nxt    = ST_CWALK;
              end
            end
            default: begin
              len_nxt   = SW'(sat_n);
              rdy_nxt   = 1'b0;
              init_nxt  = 1'b1;
              clr_nxt   = '0;
              state_nxt = ST_CLR;
            end
          endcase
        end
      end
      ST_AISS: begin
        if (pos_r >= CW'(len_r)) begin
          state_nxt = ST_DONE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_AEV;
        end
      end
      ST_AEV: begin
        if (e_size == '0) begin
          state_nxt = ST_DONE;
        end else if (!e_alloc && ((need_r + CW'(1) <= e_size) || (e_size == need_r))) begin
          fsz_nxt   = e_size;
          state_nxt = ST_ASPL;
          if ((e_size - need_r > CW'(2)) && (pos_r + need_r <= CW'(len_r) - CW'(2))) begin
            // Split: remainder becomes a free block after the taken part.
            wr_en   = 1'b1;
            wr_addr = GW'(pos_r + need_r);
            wr_data = {1'b1, 1'b0, SW'(e_size - need_r), 8'd0};
            fsz_nxt = need_r;
          end
        end else begin
          pos_nxt   = pos_r + e_size;
          state_nxt = ST_AISS;
        end
      end
      ST_ASPL: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r[GW-1:0];
        wr_data   = {1'b1, 1'b1, SW'(fsz_r), task_r};
        used_nxt  = SW'(CW'(used_r) + fsz_r);
        st_nxt    = 1'b0;
        pay_nxt   = pay_w[OFFSET_W-1:0];
        state_nxt = ST_DONE;
      end
      ST_FGISS: begin
        rd_en     = 1'b1;
        rd_addr   = g_r[GW-1:0];
        state_nxt = ST_FGEV;
      end
      ST_FGEV: begin
        if (!e_start || !e_alloc || (e_owner != task_r)) begin
          state_nxt = ST_DONE;
        end else begin
          used_nxt  = (CW'(used_r) >= e_size) ? SW'(CW'(used_r) - e_size) : '0;
          fsz_nxt   = e_size;
          pos_nxt   = g_r + e_size;
          state_nxt = (g_r + e_size < CW'(len_r)) ? ST_FNISS : ST_FWG;
        end
      end
      ST_FNISS: begin
        rd_en     = 1'b1;
        state_nxt = ST_FNEV;
      end
      ST_FNEV: begin
        if (e_start && !e_alloc) begin
          // Absorb the free block that follows and drop its header.
          fsz_nxt = fsz_r + e_size;
          wr_en   = 1'b1;
          wr_addr = pos_r[GW-1:0];
        end
        state_nxt = ST_FWG;
      end
      ST_FWG: begin
        wr_en     = 1'b1;
        wr_data   = {1'b1, 1'b0, SW'(fsz_r), 8'd0};
        pos_nxt   = '0;
        st_nxt    = 1'b0;
        state_nxt = ST_PISS;
      end
      ST_PISS: begin
        if (pos_r < g_r) begin
          rd_en     = 1'b1;
          state_nxt = ST_PEV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_PEV: begin
        if (e_size == '0) begin
          state_nxt = ST_DONE;
        end else if (!e_alloc && (pos_r + e_size == g_r)) begin
          // Grow the free block in front; keep its other fields.
          wr_en     = 1'b1;
          wr_addr   = pos_r[GW-1:0];
          wr_data   = {e_start, e_alloc, SW'(e_size + fsz_r), e_owner};
          state_nxt = ST_PDROP;
        end else begin
          pos_nxt   = pos_r + e_size;
          state_nxt = ST_PISS;
        end
      end
      ST_PDROP: begin
        wr_en     = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_CWALK: begin
        if (cnt_eval_r) begin
          cnt_eval_nxt = 1'b0;
          if (e_size == '0) begin
            state_nxt = ST_DONE;
          end else begin
            if (!e_alloc && (sz_bytes < (CW+3)'(thr_r))) begin
              cnt_nxt = cnt_r + COUNT_W'(1);
            end
            pos_nxt = pos_r + e_size;
          end
        end else if (pos_r < CW'(len_r)) begin
          rd_en        = 1'b1;
          cnt_eval_nxt = 1'b1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      default: begin
        // Hold the result until the output register is free.
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          ost_nxt   = st_r;
          opay_nxt  = pay_r;
          ocnt_nxt  = cnt_r;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      cnt_eval_r <= 1'b0;
      init_r     <= 1'b0;
      clr_r      <= '0;
      len_r      <= '0;
      used_r     <= '0;
      rdy_r      <= 1'b0;
      cfg_r      <= CFG_W'(4096);
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_eval_r <= cnt_eval_nxt;
      init_r     <= init_nxt;
      clr_r      <= clr_nxt;
      len_r      <= len_nxt;
      used_r     <= used_nxt;
      rdy_r      <= rdy_nxt;
      cfg_r      <= cfg_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    need_r <= need_nxt;
    fsz_r  <= fsz_nxt;
    g_r    <= g_nxt;
    thr_r  <= thr_nxt;
    task_r <= task_nxt;
    st_r   <= st_nxt;
    pay_r  <= pay_nxt;
    cnt_r  <= cnt_nxt;
    ost_r  <= ost_nxt;
    opay_r <= opay_nxt;
    ocnt_r <= ocnt_nxt;
  end

  assign out_ch.valid             = ov_r;
  assign out_ch.status            = ost_r;
  assign out_ch.payload_offset    = opay_r;
  assign out_ch.small_block_count = ocnt_r;
endmodule

// File: hw/rtl/hfa_checker.sv
`include "first_fit_heap_allocator_assert.svh"

module hfa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_status,
  input logic [hfa_pkg::OFFSET_W-1:0] out_payload,
  input logic [hfa_pkg::COUNT_W-1:0]  out_count
);
  import hfa_pkg::*;

  logic [1:0] pend_r, pend_nxt;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign pend_nxt = pend_r + 2'(in_xfer) - 2'(out_xfer);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `HFA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `HFA_ASSERT_IMP(a_no_extra, clk, rst_n, out_xfer, pend_r != 2'd0)
  `HFA_ASSERT_IMP(a_depth, clk, rst_n, in_xfer, (pend_r == 2'd0) || (pend_r == 2'd1))
  `HFA_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && out_status, out_payload == '0)
  `HFA_ASSERT_IMP(a_cnt_only, clk, rst_n, out_valid && (out_count != '0), (out_payload == '0) && !out_status)
endmodule

bind first_fit_heap_allocator hfa_checker u_hfa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_payload (out_ch.payload_offset),
  .out_count   (out_ch.small_block_count)
);

// File: test/hfa_tb_if.sv
// Testbench-side view of the two channels as packed structs; the block's own
// interfaces are used as they are.
package hfa_tb_pkg;
  import hfa_pkg::*;

  typedef struct packed {
    action_t             action;
    logic [REQ_W-1:0]    request_bytes;
    logic [OFFSET_W-1:0] block_offset;
    logic [TASK_W-1:0]   task_id;
  } heap_request_t;

  typedef struct packed {
    logic                status;
    logic [OFFSET_W-1:0] payload_offset;
    logic [COUNT_W-1:0]  small_block_count;
  } heap_reply_t;
endpackage

// File: test/testbench.sv
module testbench;
  import hfa_pkg::*;
  import hfa_tb_pkg::*;

  localparam int NGRAN      = HEAP_GRANULES_DEF;
  localparam int LIMIT_TIME = 10_000_000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  hfa_in_if  in_ch ();
  hfa_out_if out_ch ();

  first_fit_heap_allocator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow heap: per-granule header mirror
  bit        hdr_start [NGRAN];
  bit        hdr_alloc [NGRAN];
  int        hdr_size  [NGRAN];
  bit [7:0]  hdr_owner [NGRAN];
  int        used_gran = 0;
  bit        heap_up = 1'b0;
  int        heap_len = 0;
  int        size_reg = 4096;

  heap_request_t pending_q[$];
  int            cfg_q[$];
  bit            pick_q[$];
  heap_reply_t   expected_q[$];
  heap_request_t cur_item;
  // live allocations, for well-formed frees
  int       live_off[$];
  bit [7:0] live_task[$];

  int  fail_count = 0;
  int  sent_count = 0;
  int  recv_count = 0;
  int  total_items = 0;
  int  drv_seen = 0;
  bit  long_hold = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  rcv_phase = 0;

  function automatic void place_hdr(int g, bit al, int sz, bit [7:0] own);
    hdr_start[g] = 1; hdr_alloc[g] = al; hdr_size[g] = sz; hdr_owner[g] = own;
  endfunction

  function automatic void clear_hdr(int g);
    hdr_start[g] = 0; hdr_alloc[g] = 0; hdr_size[g] = 0; hdr_owner[g] = 0;
  endfunction

  function automatic bit heap_alloc(int req, bit [7:0] tsk, output int off);
    int need, pos, sz, take;
    off = 0;
    if (!heap_up || req == 0) return 1;
    need = (req + 7) / 8 + 1;
    if (used_gran + need > heap_len) return 1;
    pos = 0;
    while (pos < heap_len) begin
      sz = hdr_size[pos];
      if (sz == 0) return 1;
      if (!hdr_alloc[pos] && (need + 1 <= sz || sz == need)) begin
        take = sz;
        if (sz - need > 2 && pos + need <= heap_len - 2) begin
          place_hdr(pos + need, 1'b0, sz - need, 8'd0);
          take = need;
        end
        place_hdr(pos, 1'b1, take, tsk);
        used_gran += take;
        off = ((pos + 1) * 8) & 'h7FFF;
        return 0;
      end
      pos += sz;
    end
    return 1;
  endfunction

  function automatic bit heap_free(int off, bit [7:0] tsk);
    int g, sz, nx, pos, ps;
    if (!heap_up || off < 8 || off % 8 != 0) return 1;
    g = off / 8 - 1;
    if (g >= heap_len) return 1;
    if (!hdr_start[g] || !hdr_alloc[g] || hdr_owner[g] != tsk) return 1;
    sz = hdr_size[g];
    used_gran = (used_gran >= sz) ? used_gran - sz : 0;
    nx = g + sz;
    if (nx < heap_len && hdr_start[nx] && !hdr_alloc[nx]) begin
      sz += hdr_size[nx];
      clear_hdr(nx);
    end
    place_hdr(g, 1'b0, sz, 8'd0);
    pos = 0;
    while (pos < g) begin
      ps = hdr_size[pos];
      if (ps == 0) break;
      if (!hdr_alloc[pos] && pos + ps == g) begin
        hdr_size[pos] = ps + sz;
        clear_hdr(g);
        break;
      end
      pos += ps;
    end
    return 0;
  endfunction

  function automatic int count_small(int thr);
    int pos, sz, n;
    pos = 0; n = 0;
    while (pos < heap_len) begin
      sz = hdr_size[pos];
      if (sz == 0) break;
      if (!hdr_alloc[pos] && sz * 8 < thr) n++;
      pos += sz;
    end
    return n;
  endfunction

  function automatic heap_reply_t predict_reply(heap_request_t rq);
    heap_reply_t rp;
    int off, n;
    rp = '0;
    rp.status = 1'b1;
    case (rq.action)
      ACT_ALLOC: begin
        rp.status = heap_alloc(int'(rq.request_bytes), rq.task_id, off);
        if (!rp.status) rp.payload_offset = off[OFFSET_W-1:0];
      end
      ACT_FREE: rp.status = heap_free(int'(rq.block_offset), rq.task_id);
      ACT_COUNT: if (heap_up) begin
        rp.status = 1'b0;
        rp.small_block_count = COUNT_W'(count_small(int'(rq.request_bytes)));
      end
      default: begin
        n = size_reg;
        if (n < 4) n = 4;
        if (n > NGRAN) n = NGRAN;
        for (int i = 0; i < NGRAN; i++) clear_hdr(i);
        heap_len = n;
        place_hdr(0, 1'b0, n, 8'd0);
        used_gran = 0;
        heap_up = 1;
        rp.status = 1'b0;
      end
    endcase
    return rp;
  endfunction

  // Queue one item; cfg >= 0 writes the size register first, pick takes a live block.
  function automatic void add_item(action_t act, int req, int off, int tsk, int cfg, bit pick);
    heap_request_t rq;
    rq.action        = act;
    rq.request_bytes = REQ_W'(req);
    rq.block_offset  = OFFSET_W'(off);
    rq.task_id       = TASK_W'(tsk);
    pending_q.push_back(rq);
    cfg_q.push_back(cfg);
    pick_q.push_back(pick);
  endfunction

  function automatic void add_mixed(int n, int big);
    int sel, req;
    for (int i = 0; i < n; i++) begin
      sel = int'($urandom_range(0, 99));
      if (sel < 45) begin
        if ($urandom_range(0, 15) == 0) req = int'($urandom_range(0, 65535));
        else req = int'($urandom_range(1, big));
        add_item(ACT_ALLOC, req, 0, int'($urandom_range(0, 3)), -1, 1'b0);
      end else if (sel < 75) begin
        add_item(ACT_FREE, 0, int'($urandom_range(1, 40)) * 8, int'($urandom_range(0, 3)),
                 -1, 1'b1);
      end else if (sel < 83) begin
        add_item(ACT_FREE, 0, int'($urandom_range(0, 4095)), int'($urandom_range(0, 3)),
                 -1, 1'b0);
      end else begin
        add_item(ACT_COUNT, int'($urandom_range(0, big * 4)), 0, 0, -1, 1'b0);
      end
    end
  endfunction

  // Stimulus
  initial begin
    add_item(ACT_ALLOC, 40, 0, 1, -1, 1'b0);
    add_item(ACT_FREE, 0, 16, 1, -1, 1'b0);
    add_item(ACT_COUNT, 100, 0, 0, -1, 1'b0);
    add_item(ACT_INIT, 0, 0, 0, 100, 1'b0);
    add_item(ACT_ALLOC, 0, 0, 2, -1, 1'b0);
    add_item(ACT_ALLOC, 65535, 0, 2, -1, 1'b0);
    add_item(ACT_ALLOC, 65530, 0, 2, -1, 1'b0);
    add_mixed(57, 120);
    // smallest heap: whole block taken, then full
    add_item(ACT_INIT, 0, 0, 0, 3, 1'b0);
    add_item(ACT_ALLOC, 8, 0, 5, -1, 1'b0);
    add_item(ACT_ALLOC, 8, 0, 5, -1, 1'b0);
    add_item(ACT_COUNT, 64, 0, 0, -1, 1'b0);
    add_item(ACT_FREE, 0, 8, 5, -1, 1'b0);
    add_item(ACT_COUNT, 64, 0, 0, -1, 1'b0);
    add_item(ACT_INIT, 0, 0, 0, 8000, 1'b0);
    add_mixed(40, 600);
    add_item(ACT_INIT, 0, 0, 0, 50, 1'b0);
    add_mixed(28, 64);
    total_items = pending_q.size();
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Driver: bursts of offered items with random gaps, change on falling edge
  always @(negedge clk) begin
    int idx;
    cfg_we = 1'b0;
    if (!rst_n) begin
      in_ch.valid         = 1'b0;
      in_ch.action        = ACT_INIT;
      in_ch.request_bytes = '0;
      in_ch.block_offset  = '0;
      in_ch.task_id       = '0;
      cfg_wdata           = '0;
      burst_left          = int'($urandom_range(1, 8));
      gap_left            = 0;
    end else begin
      if (in_ch.valid && (sent_count != drv_seen)) begin
        // transfer took place at the last rising edge
        drv_seen    = sent_count;
        in_ch.valid = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = int'($urandom_range(1, 8));
          gap_left   = int'($urandom_range(0, 6));
        end
      end
      if (!in_ch.valid && pending_q.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cfg_q[0] >= 0) begin
          // write the size register only with nothing in flight
          if (expected_q.size() == 0) begin
            cfg_we    = 1'b1;
            cfg_wdata = CFG_W'(cfg_q[0]);
            size_reg  = cfg_q[0] & 'h1FFF;
            cfg_q[0]  = -1;
          end
        end else begin
          cur_item = pending_q.pop_front();
          void'(cfg_q.pop_front());
          if (pick_q.pop_front() && live_off.size() > 0) begin
            idx = int'($urandom_range(0, live_off.size() - 1));
            cur_item.block_offset = OFFSET_W'(live_off[idx]);
            cur_item.task_id      = live_task[idx];
            if ($urandom_range(0, 7) == 0) cur_item.task_id = live_task[idx] + 8'd1;
          end
          in_ch.action        = cur_item.action;
          in_ch.request_bytes = cur_item.request_bytes;
          in_ch.block_offset  = cur_item.block_offset;
          in_ch.task_id       = cur_item.task_id;
          in_ch.valid         = 1'b1;
        end
      end
    end
  end

  // Receiver: own stall pattern, plus one long hold
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
      rcv_phase    = 0;
    end else begin
      rcv_phase++;
      out_ch.ready = !long_hold && ((rcv_phase % 11) < 8);
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    wait (sent_count >= 12);
    long_hold = 1'b1;
    repeat (300) @(posedge clk);
    long_hold = 1'b0;
  end

  // Monitor: predict on input transfer, check on result transfer
  always @(posedge clk) begin
    heap_reply_t exp_rp;
    heap_reply_t got_rp;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got_rp.status            = out_ch.status;
        got_rp.payload_offset    = out_ch.payload_offset;
        got_rp.small_block_count = out_ch.small_block_count;
        recv_count++;
        if (expected_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          fail_count++;
        end else begin
          exp_rp = expected_q.pop_front();
          if (got_rp.status !== exp_rp.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp_rp.status, got_rp.status);
            fail_count++;
          end
          if (got_rp.payload_offset !== exp_rp.payload_offset) begin
            $error("payload_offset mismatch: expected %0d, actual %0d",
                   exp_rp.payload_offset, got_rp.payload_offset);
            fail_count++;
          end
          if (got_rp.small_block_count !== exp_rp.small_block_count) begin
            $error("small_block_count mismatch: expected %0d, actual %0d",
                   exp_rp.small_block_count, got_rp.small_block_count);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        exp_rp = predict_reply(cur_item);
        expected_q.push_back(exp_rp);
        sent_count++;
        if (cur_item.action == ACT_ALLOC && !exp_rp.status) begin
          live_off.push_back(int'(exp_rp.payload_offset));
          live_task.push_back(cur_item.task_id);
        end else if (cur_item.action == ACT_FREE && !exp_rp.status) begin
          for (int k = 0; k < live_off.size(); k++) begin
            if (live_off[k] == int'(cur_item.block_offset)) begin
              live_off.delete(k);
              live_task.delete(k);
              break;
            end
          end
        end else if (cur_item.action == ACT_INIT) begin
          live_off.delete();
          live_task.delete();
        end
      end
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    wait (total_items > 0 && recv_count >= total_items);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0 && recv_count == total_items) begin
      $display("first_fit_heap_allocator verification clean");
    end else begin
      $display("first_fit_heap_allocator verification failed");
    end
    $finish;
  end

  initial begin
    #LIMIT_TIME;
    $display("first_fit_heap_allocator verification failed");
    $finish;
  end
endmodule
